// ----- rtl/core/rsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rsc_pkg
// shared types and constants for the rotating substitution cipher
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned STEP_RESET = 1;

  typedef logic [BYTE_W-1:0] byte_t;

  // request type codes
  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_ENCRYPT = 2'd1,
    REQ_DECRYPT = 2'd2,
    REQ_NONE    = 2'd3
  } req_code_t;

  // what the result stage has to do with the table read data
  typedef enum logic [1:0] {
    RES_ENC,
    RES_DEC,
    RES_ERR
  } res_kind_t;

endpackage

// ----- rtl/core/rsc_ram.sv -----
// ----------------------------------------------------------------------------
// rsc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/rotating_substitution_cipher.sv -----
// ----------------------------------------------------------------------------
// rotating_substitution_cipher
// byte substitution cipher with per-direction rotating offsets
// ----------------------------------------------------------------------------
// encrypt and decrypt pass the table read (s1), then the result register
// throughput: one item per cycle while no read is stuck in s1 under
// rsp_stall, set by the single read port of each table ram; loads and
// unused codes give no result
// reset: rst clears offsets, positions and valid flags and sets step_period
// to 1; table contents are left as they are until loaded
module rotating_substitution_cipher (
  input  logic                  clk,
  input  logic                  rst,
  // configuration: step_period
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  rsc_pkg::byte_t        cfg_data,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            req_type,
  input  logic                  block_start,
  input  rsc_pkg::byte_t        table_index,
  input  rsc_pkg::byte_t        data_byte,
  // result channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsc_pkg::byte_t        result_byte,
  output logic                  error_flag
);

  import rsc_pkg::*;

  // configuration register, always writable
  byte_t step_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= byte_t'(STEP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      step_period <= cfg_data;
    end
  end

  // offset and position state per direction
  byte_t enc_offset, enc_offset_next;
  byte_t dec_offset, dec_offset_next;
  byte_t enc_position, enc_position_next;
  byte_t dec_position, dec_position_next;

  // table read stage (s1) and result register
  logic      s1_valid;
  res_kind_t s1_kind;
  byte_t     s1_offset;

  logic  out_take;   // result register can load this cycle
  logic  accept;
  logic  is_load, is_enc, is_dec, period_zero;
  logic  s1_load;
  byte_t enc_addr;
  byte_t subst_rd, inverse_rd;
  byte_t result_next;

  assign out_take  = !rsp_valid || !rsp_stall;
  // hold the request side only when a read result is stuck in s1
  assign req_stall = s1_valid && !out_take;
  assign accept    = req_valid && !req_stall;

  assign is_load     = accept && (req_type == REQ_LOAD);
  assign is_enc      = accept && (req_type == REQ_ENCRYPT);
  assign is_dec      = accept && (req_type == REQ_DECRYPT);
  assign period_zero = (step_period == '0);
  assign s1_load     = is_enc || is_dec;

  // position counting: restart at block start or when out of range after a
  // period change; bump the offset at position zero, then advance and wrap
  function automatic logic [2*BYTE_W-1:0] advance(byte_t pos, byte_t offset,
                                                  logic start, byte_t period);
    byte_t p;
    byte_t pn;
    logic  bump;
    p    = (start || (pos >= period)) ? '0 : pos;
    bump = (p == '0);
    pn   = p + byte_t'(1);
    if (pn >= period) begin
      pn = '0;
    end
    return {offset + byte_t'(bump), pn};
  endfunction

  logic [2*BYTE_W-1:0] enc_adv, dec_adv;

  always_comb begin
    enc_adv           = advance(enc_position, enc_offset, block_start, step_period);
    dec_adv           = advance(dec_position, dec_offset, block_start, step_period);
    enc_offset_next   = enc_offset;
    enc_position_next = enc_position;
    dec_offset_next   = dec_offset;
    dec_position_next = dec_position;
    // zero period leaves all state alone
    if (is_enc && !period_zero) begin
      enc_offset_next   = enc_adv[2*BYTE_W-1:BYTE_W];
      enc_position_next = enc_adv[BYTE_W-1:0];
    end
    if (is_dec && !period_zero) begin
      dec_offset_next   = dec_adv[2*BYTE_W-1:BYTE_W];
      dec_position_next = dec_adv[BYTE_W-1:0];
    end
    enc_addr = data_byte + enc_adv[2*BYTE_W-1:BYTE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_offset   <= '0;
      enc_position <= '0;
      dec_offset   <= '0;
      dec_position <= '0;
    end else begin
      enc_offset   <= enc_offset_next;
      enc_position <= enc_position_next;
      dec_offset   <= dec_offset_next;
      dec_position <= dec_position_next;
    end
  end

  // forward table and its inverse; a load writes both, one item per cycle
  // so a read never meets a write to the same entry at the same edge
  rsc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_SIZE)
  ) u_subst_ram (
    .clk     (clk),
    .wr_en   (is_load),
    .wr_addr (table_index),
    .wr_data (data_byte),
    .rd_en   (is_enc),
    .rd_addr (enc_addr),
    .rd_data (subst_rd)
  );

  rsc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_SIZE)
  ) u_inverse_ram (
    .clk     (clk),
    .wr_en   (is_load),
    .wr_addr (data_byte),
    .wr_data (table_index),
    .rd_en   (is_dec),
    .rd_addr (data_byte),
    .rd_data (inverse_rd)
  );

  // s1 tracks the outstanding table read; the ram output holds while stuck
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || out_take) begin
      s1_valid <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_offset <= dec_offset_next;
      if (period_zero) begin
        s1_kind <= RES_ERR;
      end else if (is_enc) begin
        s1_kind <= RES_ENC;
      end else begin
        s1_kind <= RES_DEC;
      end
    end
  end

  always_comb begin
    case (s1_kind)
      RES_ENC: result_next = subst_rd;
      RES_DEC: result_next = inverse_rd - s1_offset;
      default: result_next = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_take) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid) begin
      result_byte <= result_next;
      error_flag  <= (s1_kind == RES_ERR);
    end
  end

  // a read stuck behind a stalled result must not be dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && rsp_stall |=> s1_valid)
    else $error("pending table read lost under result stall");

  // an error result always carries a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error_flag |-> result_byte == '0)
    else $error("error result with nonzero byte");

  // request stall only when a read is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid)
    else $error("request stalled with empty read stage");

  // a new result comes from the read stage
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(s1_valid))
    else $error("result appeared without a table read");

  // zero period leaves the offsets alone
  a_zero_period: assert property (@(posedge clk) disable iff (rst)
    accept && period_zero |=> $stable(enc_offset) && $stable(dec_offset))
    else $error("offset changed with zero step period");

endmodule

// ----- sim/rotating_substitution_cipher_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotating_substitution_cipher_test
// self-checking bench for the rotating substitution cipher: a short table of
// hand-made transfers (extremes, error period, ignored code, offset wrap,
// position reset after a period change, non-permutation loads) is followed
// by a random permutation load and random phases at several step periods,
// each checked against a cycle-free behavioral predictor
// ----------------------------------------------------------------------------
module rotating_substitution_cipher_test;
  import rsc_pkg::*;

  localparam int CLK_PERIOD       = 4;
  localparam int RESET_CYCLES     = 9;
  // a result passes table read and result register; loads may still be in
  // flight at the last result, so give the pipe a little more before config
  localparam int SETTLE_CYCLES    = 4;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT      = 200000;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  // one row of the directed table; typed-in results only where obvious
  typedef struct packed {
    row_kind_t kind;
    req_code_t code;
    logic      start;
    byte_t     index;
    byte_t     data;
    logic      typed;
    byte_t     typed_byte;
    logic      typed_err;
  } stim_row_t;

  typedef struct packed {
    byte_t result_byte;
    logic  error_flag;
  } cipher_out_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  cfg_valid;
  logic  cfg_ready;
  byte_t cfg_data;
  logic  req_valid;
  logic  req_stall;
  logic [1:0] req_type;
  logic  block_start;
  byte_t table_index;
  byte_t data_byte;
  logic  rsp_valid;
  logic  rsp_stall;
  byte_t result_byte;
  logic  error_flag;

  // predictor state, updated at every accepted request transfer
  byte_t subst_model [TABLE_SIZE];
  byte_t inverse_model [TABLE_SIZE];
  byte_t enc_ofs = '0;
  byte_t dec_ofs = '0;
  byte_t enc_pos = '0;
  byte_t dec_pos = '0;
  byte_t step_period_model = byte_t'(STEP_RESET);

  cipher_out_t pending_results[$];
  int  mismatches = 0;
  int  cycle_count = 0;
  // shared between sender and receiver: phases with no idling at all
  bit  no_idle = 1'b0;
  // set by the stimulus, picked up and counted down by the receiver
  bit  long_hold_req = 1'b0;
  // request valid is still up with an already accepted payload
  bit  req_offered = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  rotating_substitution_cipher i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .block_start (block_start),
    .table_index (table_index),
    .data_byte   (data_byte),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .result_byte (result_byte),
    .error_flag  (error_flag)
  );

  // directed table, walked once after reset (step period 1, offsets 0)
  stim_row_t directed_rows [23] = '{
    // loads at both ends of index and value range
    '{ROW_REQ, REQ_LOAD,    1'b0, 8'h00, 8'hff, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_LOAD,    1'b0, 8'hff, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_LOAD,    1'b0, 8'h01, 8'h80, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_LOAD,    1'b0, 8'h02, 8'h7f, 1'b0, 8'h00, 1'b0},
    // first encrypt after reset: offset 1, ff + 1 wraps to entry 0
    '{ROW_REQ, REQ_ENCRYPT, 1'b1, 8'h00, 8'hff, 1'b1, 8'hff, 1'b0},
    '{ROW_REQ, REQ_ENCRYPT, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    // first decrypt after reset: ff - 1
    '{ROW_REQ, REQ_DECRYPT, 1'b1, 8'h00, 8'h00, 1'b1, 8'hfe, 1'b0},
    // inverse 0 minus offset wraps below zero
    '{ROW_REQ, REQ_DECRYPT, 1'b0, 8'h00, 8'hff, 1'b0, 8'h00, 1'b0},
    // unused code is dropped
    '{ROW_REQ, REQ_NONE,    1'b1, 8'haa, 8'h55, 1'b0, 8'h00, 1'b0},
    // zero period: error result, state kept
    '{ROW_CFG, REQ_NONE,    1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_ENCRYPT, 1'b0, 8'h00, 8'h5a, 1'b1, 8'h00, 1'b1},
    '{ROW_REQ, REQ_DECRYPT, 1'b1, 8'h00, 8'ha5, 1'b1, 8'h00, 1'b1},
    // longest period: offset steps only at position 0 or block start
    '{ROW_CFG, REQ_NONE,    1'b0, 8'h00, 8'hff, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_ENCRYPT, 1'b0, 8'h00, 8'hfe, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_ENCRYPT, 1'b0, 8'h00, 8'hfe, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_ENCRYPT, 1'b1, 8'h00, 8'hfd, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DECRYPT, 1'b0, 8'h00, 8'h80, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DECRYPT, 1'b0, 8'h00, 8'h7f, 1'b0, 8'h00, 1'b0},
    // shrink the period below the running positions
    '{ROW_CFG, REQ_NONE,    1'b0, 8'h00, 8'h01, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_ENCRYPT, 1'b0, 8'h00, 8'hfc, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DECRYPT, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    // second index for value 80: inverse keeps the latest
    '{ROW_REQ, REQ_LOAD,    1'b0, 8'h03, 8'h80, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DECRYPT, 1'b0, 8'h00, 8'h80, 1'b0, 8'h00, 1'b0}
  };

  // idle cycles before the next transfer on either side
  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 9);
  endfunction

  // position counter step; returns 1 when the offset has to move
  function automatic bit advance_position(inout byte_t pos, input bit start);
    int p;
    p = pos;
    if (start || p >= step_period_model) p = 0;
    advance_position = (p == 0);
    p++;
    if (p >= step_period_model) p = 0;
    pos = byte_t'(p);
  endfunction

  // behavior of one accepted request on the predictor state
  function automatic void cipher_step(input req_code_t code, input bit start,
                                      input byte_t idx, input byte_t data,
                                      output bit produces, output cipher_out_t res);
    produces = 1'b0;
    res = '0;
    case (code)
      REQ_LOAD: begin
        subst_model[idx]    = data;
        inverse_model[data] = idx;
      end
      REQ_ENCRYPT, REQ_DECRYPT: begin
        produces = 1'b1;
        if (step_period_model == 0) begin
          res.error_flag = 1'b1;
        end else if (code == REQ_ENCRYPT) begin
          if (advance_position(enc_pos, start)) enc_ofs = enc_ofs + 8'd1;
          res.result_byte = subst_model[byte_t'(data + enc_ofs)];
        end else begin
          if (advance_position(dec_pos, start)) dec_ofs = dec_ofs + 8'd1;
          res.result_byte = byte_t'(inverse_model[data] - dec_ofs);
        end
      end
      default: ;
    endcase
  endfunction

  // take request valid down when the last payload has already gone
  task automatic drop_request_valid();
    if (req_offered) begin
      req_valid   <= 1'b0;
      req_offered = 1'b0;
    end
  endtask

  // one request transfer; the result is predicted at the accepting edge
  task automatic offer_request(input req_code_t code, input bit start,
                               input byte_t idx, input byte_t data, input bit typed,
                               input byte_t typed_byte, input bit typed_err);
    int          gap;
    bit          produces;
    cipher_out_t want;
    gap = draw_wait();
    if (gap > 0) begin
      drop_request_valid();
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= code;
    block_start <= start;
    table_index <= idx;
    data_byte   <= data;
    req_offered = 1'b1;
    do @(posedge clk); while (req_stall);
    cipher_step(code, start, idx, data, produces, want);
    if (produces) begin
      if (typed) begin
        want.result_byte = typed_byte;
        want.error_flag  = typed_err;
      end
      pending_results.push_back(want);
    end
  endtask

  // step_period may only change with nothing in flight
  task automatic write_step_period(input byte_t value);
    drop_request_valid();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_period_model = value;
  endtask

  // random traffic at one step period: mostly encrypt and decrypt blocks
  // opened by block_start, plus reloads, dropped codes and stray starts
  task automatic run_random_phase(input byte_t period, input int count,
                                  input bit gapless, input bit long_hold);
    int        pick;
    int        enc_left;
    int        dec_left;
    bit        start;
    req_code_t code;
    enc_left = 0;
    dec_left = 0;
    write_step_period(period);
    no_idle = gapless;
    if (long_hold) long_hold_req = 1'b1;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        offer_request(REQ_LOAD, 1'($urandom_range(0, 1)), byte_t'($urandom),
                      byte_t'($urandom), 1'b0, 8'h00, 1'b0);
      end else if (pick < 13) begin
        offer_request(REQ_NONE, 1'($urandom_range(0, 1)), byte_t'($urandom),
                      byte_t'($urandom), 1'b0, 8'h00, 1'b0);
      end else begin
        code = ($urandom_range(0, 1) == 1) ? REQ_ENCRYPT : REQ_DECRYPT;
        // each direction runs its own block stream
        if (code == REQ_ENCRYPT) begin
          start = (enc_left == 0);
          if (start) enc_left = $urandom_range(1, 24);
          enc_left--;
        end else begin
          start = (dec_left == 0);
          if (start) dec_left = $urandom_range(1, 24);
          dec_left--;
        end
        // occasional broken block framing
        if ($urandom_range(0, 19) == 0) start = ~start;
        offer_request(code, start, byte_t'($urandom), byte_t'($urandom),
                      1'b0, 8'h00, 1'b0);
      end
    end
    no_idle = 1'b0;
  endtask

  // stimulus: reset, directed table, full table load, random phases
  initial begin
    byte_t perm [TABLE_SIZE];
    byte_t swap;
    int    j;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    req_valid   <= 1'b0;
    req_type    <= REQ_NONE;
    block_start <= 1'b0;
    table_index <= '0;
    data_byte   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_step_period(directed_rows[i].data);
      end else begin
        offer_request(directed_rows[i].code, directed_rows[i].start,
                      directed_rows[i].index, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].typed_byte,
                      directed_rows[i].typed_err);
      end
    end

    // random permutation for the whole table, so no later read hits an
    // entry that was never written
    for (int i = 0; i < TABLE_SIZE; i++) perm[i] = byte_t'(i);
    for (int i = TABLE_SIZE - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      swap    = perm[i];
      perm[i] = perm[j];
      perm[j] = swap;
    end
    for (int i = 0; i < TABLE_SIZE; i++) begin
      offer_request(REQ_LOAD, 1'b0, byte_t'(i), perm[i], 1'b0, 8'h00, 1'b0);
    end

    run_random_phase(8'd1,   150, 1'b0, 1'b0);
    run_random_phase(8'd2,   150, 1'b1, 1'b0);
    run_random_phase(8'd0,    60, 1'b0, 1'b0);
    run_random_phase(8'd255, 150, 1'b0, 1'b1);
    run_random_phase(8'd3,   150, 1'b0, 1'b0);
    run_random_phase(byte_t'($urandom_range(4, 40)), 160, 1'b0, 1'b0);
    run_random_phase(8'd7,   150, 1'b1, 1'b1);
    run_random_phase(8'd1,   305, 1'b0, 1'b0);

    // drain, then give the pipe time to show any stray result
    drop_request_valid();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side: random stall per transfer, plus a long hold-off on request
  // so the block backs up and stalls its request channel
  initial begin : result_sink
    int          stall_left;
    int          hold_left;
    cipher_out_t want;
    stall_left = 0;
    hold_left  = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no result pending: result_byte %h error_flag %b",
                 result_byte, error_flag);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (result_byte !== want.result_byte) begin
            $error("result_byte: expected %h, actual %h", want.result_byte, result_byte);
            mismatches++;
          end
          if (error_flag !== want.error_flag) begin
            $error("error_flag: expected %b, actual %b", want.error_flag, error_flag);
            mismatches++;
          end
        end
        stall_left = draw_wait();
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
